// ----- hw/rtl/nau_pkg.sv -----
package nau_pkg;

    localparam int MAX_LEN    = 64;
    localparam int FRAC_BITS  = 12;
    localparam int DATA_W     = 16;
    localparam int LEAK_W     = 13;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEAK_W;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int N_W        = DATA_W - FRAC_BITS;
    localparam int EQ_W       = FRAC_BITS + 2;
    localparam int SUM_W      = FRAC_BITS + ADDR_W + 1;

    localparam int Q_W        = 33;
    localparam int SS_W       = Q_W + 2;
    localparam int MUL_W      = 2 * Q_W;
    localparam int MUL_SPLIT  = 16;
    localparam int SER_TERMS  = 24;
    localparam int K_W        = $clog2(SER_TERMS + 1);
    localparam int DIV_W      = 48;
    localparam int DVS_W      = Q_W + 1;
    localparam int DCNT_W     = $clog2(DIV_W + 1);

    localparam int ONE_FX     = 1 << FRAC_BITS;
    localparam int HALF_FX    = 1 << (FRAC_BITS - 1);
    localparam int LEAK_FRAC  = 12;
    localparam int LEAK_HALF  = 1 << (LEAK_FRAC - 1);
    localparam int LEAK_RESET = 41;

    localparam logic [MODE_W-1:0] MODE_SIGMOID  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOFTMAX  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEAKY    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SIG_D    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ID_D     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RELU_D   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK = 1'b1;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_OUT_DIRECT,
        CMD_SM_STORE,
        CMD_SIG_LOAD,
        CMD_EXP_INIT,
        CMD_SER_E1,
        CMD_SER_ADD,
        CMD_MUL_HI,
        CMD_DIV_TERM,
        CMD_TERM_SET,
        CMD_SER_E,
        CMD_SER_E1SET,
        CMD_POW_MUL,
        CMD_POW_SET,
        CMD_SIG_DIV,
        CMD_SIG_OUT,
        CMD_SM_T,
        CMD_SM_EQ,
        CMD_SM_B,
        CMD_SM_DIV,
        CMD_SM_OUT
    } cmd_t;

    typedef struct packed {
        cmd_t op;
    } nau_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              div_busy;
        logic              term_zero;
        logic              k_end;
        logic              n_zero;
        logic              e_zero;
        logic              idx_last;
    } nau_status_t;

endpackage

// ----- hw/rtl/nau_ram.sv -----
module nau_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/nau_ctrl.sv -----
module nau_ctrl import nau_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        last,
    output logic        in_ready,
    input  nau_status_t status,
    output nau_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXP_INIT,
        S_TERM,
        S_MUL_HI,
        S_DIV_START,
        S_DIV_WAIT,
        S_E1_INIT,
        S_POW,
        S_POW_HI,
        S_POW_SET,
        S_SIG_DIV,
        S_SIG_WAIT,
        S_SIG_OUT,
        S_A_RD,
        S_A_T,
        S_A_EQ,
        S_B_INIT,
        S_B_RD,
        S_B_DIV,
        S_B_WAIT,
        S_B_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   ret_sm_reg, ret_sm_next;
    state_t exp_done;

    always_comb
    begin
        exp_done    = ret_sm_reg ? S_A_EQ : S_SIG_DIV;
        state_next  = state_reg;
        phase_next  = phase_reg;
        ret_sm_next = ret_sm_reg;
        cmd.op      = CMD_NONE;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    if (status.mode == MODE_SOFTMAX)
                    begin
                        cmd.op = CMD_SM_STORE;
                        if (last)
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else if (status.mode == MODE_SIGMOID)
                    begin
                        cmd.op      = CMD_SIG_LOAD;
                        ret_sm_next = 1'b0;
                        state_next  = S_EXP_INIT;
                    end
                    else
                    begin
                        cmd.op = CMD_OUT_DIRECT;
                    end
                end
            end
            S_EXP_INIT:
            begin
                cmd.op     = CMD_EXP_INIT;
                phase_next = 1'b0;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (status.term_zero || status.k_end)
                begin
                    if (!phase_reg)
                    begin
                        cmd.op     = CMD_SER_E;
                        state_next = status.n_zero ? exp_done : S_E1_INIT;
                    end
                    else
                    begin
                        cmd.op     = CMD_SER_E1SET;
                        state_next = S_POW;
                    end
                end
                else
                begin
                    cmd.op     = CMD_SER_ADD;
                    state_next = S_MUL_HI;
                end
            end
            S_MUL_HI:
            begin
                cmd.op     = CMD_MUL_HI;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.op     = CMD_DIV_TERM;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = CMD_TERM_SET;
                    state_next = S_TERM;
                end
            end
            S_E1_INIT:
            begin
                cmd.op     = CMD_SER_E1;
                phase_next = 1'b1;
                state_next = S_TERM;
            end
            S_POW:
            begin
                if (status.n_zero || status.e_zero)
                begin
                    state_next = exp_done;
                end
                else
                begin
                    cmd.op     = CMD_POW_MUL;
                    state_next = S_POW_HI;
                end
            end
            S_POW_HI:
            begin
                cmd.op     = CMD_MUL_HI;
                state_next = S_POW_SET;
            end
            S_POW_SET:
            begin
                cmd.op     = CMD_POW_SET;
                state_next = S_POW;
            end
            S_SIG_DIV:
            begin
                cmd.op     = CMD_SIG_DIV;
                state_next = S_SIG_WAIT;
            end
            S_SIG_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_SIG_OUT;
                end
            end
            S_SIG_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = CMD_SIG_OUT;
                    state_next = S_IDLE;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_T;
            end
            S_A_T:
            begin
                cmd.op      = CMD_SM_T;
                ret_sm_next = 1'b1;
                state_next  = S_EXP_INIT;
            end
            S_A_EQ:
            begin
                cmd.op     = CMD_SM_EQ;
                state_next = status.idx_last ? S_B_INIT : S_A_RD;
            end
            S_B_INIT:
            begin
                cmd.op     = CMD_SM_B;
                state_next = S_B_RD;
            end
            S_B_RD:
            begin
                state_next = S_B_DIV;
            end
            S_B_DIV:
            begin
                cmd.op     = CMD_SM_DIV;
                state_next = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_B_OUT;
                end
            end
            S_B_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = CMD_SM_OUT;
                    state_next = status.idx_last ? S_IDLE : S_B_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
            ret_sm_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ret_sm_reg <= ret_sm_next;
        end
    end

endmodule

// ----- hw/rtl/nau_dp.sv -----
module nau_dp import nau_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last,
    output logic signed [DATA_W-1:0] result,
    output logic                     end_of_vector,
    output logic                     overflow,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  nau_cmd_t                 cmd,
    output nau_status_t              status
);

    localparam int SAT_W = 40;
    localparam int LP_W  = DATA_W + LEAK_W + 1;
    localparam int XE_W  = DATA_W + 2;
    localparam int DP_W  = 2 * XE_W;
    localparam int RD_W  = LEAK_W + FRAC_BITS + 1;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32767);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(32768);
    localparam logic [Q_W-1:0] Q32_ONE = Q_W'(1) << 32;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = 16'sh7FFF;
        end
        else if (v < SAT_LO)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // configuration, softmax bookkeeping, output valid and divider counter
    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [LEAK_W-1:0]        leak_reg, leak_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic                     ovf_reg, ovf_next;
    logic                     ov_reg, ov_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;

    // working registers
    logic                     xneg_reg, xneg_next;
    logic                     last_reg, last_next;
    logic [DATA_W-1:0]        t_reg, t_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [Q_W-1:0]           y_reg, y_next;
    logic [Q_W-1:0]           term_reg, term_next;
    logic signed [SS_W-1:0]   ssum_reg, ssum_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [Q_W-1:0]           e_reg, e_next;
    logic [Q_W-1:0]           e1_reg, e1_next;
    logic [Q_W-MUL_SPLIT-1:0] mah_reg, mah_next;
    logic [Q_W-1:0]           mb_reg, mb_next;
    logic [MUL_W-1:0]         acc_reg, acc_next;
    logic [DIV_W-1:0]         dvd_reg, dvd_next;
    logic [DVS_W:0]           rem_reg, rem_next;
    logic [DVS_W-1:0]         dvs_reg, dvs_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [SUM_W-1:0]         smsum_reg, smsum_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                     eov_reg, eov_next;
    logic                     ovo_reg, ovo_next;

    // combinational helpers
    logic signed [LP_W-1:0]   lp;
    logic signed [DATA_W-1:0] lr;
    logic signed [XE_W-1:0]   xe, om;
    logic signed [DP_W-1:0]   dprod;
    logic signed [DATA_W-1:0] dr;
    logic [RD_W-1:0]          rdv;
    logic signed [DATA_W-1:0] rdr;
    logic signed [DATA_W-1:0] ew;
    logic [Q_W-1:0]           ser_clamp;
    logic [DATA_W:0]          mag;
    logic [DATA_W:0]          diff;
    logic [Q_W:0]             e_round;
    logic [EQ_W-1:0]          eq;
    logic [MUL_W-1:0]         pw;
    logic [DVS_W-1:0]         den;
    logic [DIV_W-1:0]         num;
    logic [DVS_W:0]           r2;
    logic [DATA_W-1:0]        qsat;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     idx_last;

    nau_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // elementwise functions
    always_comb
    begin
        lp    = sample * $signed({1'b0, leak_reg});
        lr    = sat16(SAT_W'((lp + LP_W'(LEAK_HALF)) >>> LEAK_FRAC));
        xe    = XE_W'(sample);
        om    = XE_W'(ONE_FX) - xe;
        dprod = xe * om;
        dr    = sat16(SAT_W'((dprod + DP_W'(HALF_FX)) >>> FRAC_BITS));
        rdv   = (RD_W'(leak_reg) << FRAC_BITS) + RD_W'(LEAK_HALF);
        rdr   = sat16(SAT_W'(rdv >> LEAK_FRAC));
        case (mode_reg)
            MODE_LEAKY:  ew = (sample > 0) ? sample : lr;
            MODE_SIG_D:  ew = dr;
            MODE_ID_D:   ew = DATA_W'(ONE_FX);
            MODE_RELU_D: ew = sample[DATA_W-1] ? rdr : DATA_W'(ONE_FX);
            default:     ew = sample;
        endcase
    end

    always_comb
    begin
        idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
        if (ssum_reg[SS_W-1])
        begin
            ser_clamp = '0;
        end
        else if (ssum_reg[SS_W-2:0] > (SS_W-1)'(Q32_ONE))
        begin
            ser_clamp = Q32_ONE;
        end
        else
        begin
            ser_clamp = ssum_reg[Q_W-1:0];
        end
        mag     = sample[DATA_W-1] ? -(DATA_W+1)'(sample) : (DATA_W+1)'(sample);
        diff    = (DATA_W+1)'(max_reg) - (DATA_W+1)'(ram_rdata);
        e_round = (Q_W+1)'(e_reg) + (Q_W+1)'(1 << (31 - FRAC_BITS));
        eq      = e_round[Q_W:32-FRAC_BITS];
        pw      = acc_reg + MUL_W'(64'd1 << 31);
        den     = DVS_W'(e_reg) + DVS_W'(Q32_ONE);
        num     = xneg_reg ? (DIV_W'(e_reg) << FRAC_BITS) : (DIV_W'(1) << (32 + FRAC_BITS));
        r2      = {rem_reg[DVS_W-1:0], dvd_reg[DIV_W-1]};
        qsat    = (dvd_reg > DIV_W'(32767)) ? 16'h7FFF : dvd_reg[DATA_W-1:0];
    end

    always_comb
    begin
        mode_next  = mode_reg;
        leak_next  = leak_reg;
        cnt_next   = cnt_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg && !out_ready;
        dcnt_next  = dcnt_reg;
        xneg_next  = xneg_reg;
        last_next  = last_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        y_next     = y_reg;
        term_next  = term_reg;
        ssum_next  = ssum_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        e1_next    = e1_reg;
        mah_next   = mah_reg;
        mb_next    = mb_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        idx_next   = idx_reg;
        smsum_next = smsum_reg;
        res_next   = res_reg;
        eov_next   = eov_reg;
        ovo_next   = ovo_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = DATA_W'(eq);

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE: mode_next = cfg_data[MODE_W-1:0];
                REG_LEAK: leak_next = cfg_data[LEAK_W-1:0];
                default:  mode_next = mode_reg;
            endcase
        end

        // restoring divider, one quotient bit per cycle
        if (dcnt_reg != '0)
        begin
            dcnt_next = dcnt_reg - DCNT_W'(1);
            if (r2 >= {1'b0, dvs_reg})
            begin
                rem_next = r2 - {1'b0, dvs_reg};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = r2;
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
        end

        case (cmd.op)
            CMD_OUT_DIRECT:
            begin
                res_next = ew;
                eov_next = last;
                ovo_next = 1'b0;
                ov_next  = 1'b1;
            end
            CMD_SM_STORE:
            begin
                if (cnt_reg < CNT_W'(MAX_LEN))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[ADDR_W-1:0];
                    ram_wdata = sample;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (sample > max_reg)
                    begin
                        max_next = sample;
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (last)
                begin
                    idx_next   = '0;
                    smsum_next = '0;
                end
            end
            CMD_SIG_LOAD:
            begin
                xneg_next = sample[DATA_W-1];
                last_next = last;
                t_next    = mag[DATA_W-1:0];
            end
            CMD_SM_T:
            begin
                t_next = diff[DATA_W-1:0];
            end
            CMD_EXP_INIT:
            begin
                n_next    = t_reg[DATA_W-1:FRAC_BITS];
                y_next    = Q_W'(t_reg[FRAC_BITS-1:0]) << (31 - FRAC_BITS);
                term_next = Q32_ONE;
                ssum_next = '0;
                k_next    = '0;
            end
            CMD_SER_E1:
            begin
                y_next    = Q32_ONE >> 1;
                term_next = Q32_ONE;
                ssum_next = '0;
                k_next    = '0;
            end
            CMD_SER_ADD:
            begin
                if (k_reg[0])
                begin
                    ssum_next = ssum_reg - SS_W'(term_reg);
                end
                else
                begin
                    ssum_next = ssum_reg + SS_W'(term_reg);
                end
                acc_next = MUL_W'(term_reg[MUL_SPLIT-1:0]) * MUL_W'(y_reg);
                mah_next = term_reg[Q_W-1:MUL_SPLIT];
                mb_next  = y_reg;
            end
            CMD_POW_MUL:
            begin
                acc_next = MUL_W'(e_reg[MUL_SPLIT-1:0]) * MUL_W'(e1_reg);
                mah_next = e_reg[Q_W-1:MUL_SPLIT];
                mb_next  = e1_reg;
            end
            CMD_MUL_HI:
            begin
                acc_next = acc_reg + ((MUL_W'(mah_reg) * MUL_W'(mb_reg)) << MUL_SPLIT);
            end
            CMD_DIV_TERM:
            begin
                dvd_next  = DIV_W'(acc_reg[MUL_W-1:31]);
                dvs_next  = DVS_W'(k_reg) + DVS_W'(1);
                rem_next  = '0;
                dcnt_next = DCNT_W'(DIV_W);
            end
            CMD_TERM_SET:
            begin
                term_next = dvd_reg[Q_W-1:0];
                k_next    = k_reg + K_W'(1);
            end
            CMD_SER_E:
            begin
                e_next = ser_clamp;
            end
            CMD_SER_E1SET:
            begin
                e1_next = ser_clamp;
            end
            CMD_POW_SET:
            begin
                e_next = pw[Q_W+31:32];
                n_next = n_reg - N_W'(1);
            end
            CMD_SIG_DIV:
            begin
                dvd_next  = num + DIV_W'(den >> 1);
                dvs_next  = den;
                rem_next  = '0;
                dcnt_next = DCNT_W'(DIV_W);
            end
            CMD_SIG_OUT:
            begin
                res_next = qsat;
                eov_next = last_reg;
                ovo_next = 1'b0;
                ov_next  = 1'b1;
            end
            CMD_SM_EQ:
            begin
                ram_we     = 1'b1;
                smsum_next = smsum_reg + SUM_W'(eq);
                idx_next   = idx_reg + ADDR_W'(1);
            end
            CMD_SM_B:
            begin
                idx_next = '0;
            end
            CMD_SM_DIV:
            begin
                dvd_next  = (DIV_W'(ram_rdata) << FRAC_BITS) + DIV_W'(smsum_reg >> 1);
                dvs_next  = (smsum_reg == '0) ? DVS_W'(1) : DVS_W'(smsum_reg);
                rem_next  = '0;
                dcnt_next = DCNT_W'(DIV_W);
            end
            CMD_SM_OUT:
            begin
                res_next = qsat;
                eov_next = idx_last;
                ovo_next = ovf_reg;
                ov_next  = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                if (idx_last)
                begin
                    cnt_next = '0;
                    max_next = 16'sh8000;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SIGMOID;
            leak_reg <= LEAK_W'(LEAK_RESET);
            cnt_reg  <= '0;
            max_reg  <= 16'sh8000;
            ovf_reg  <= 1'b0;
            ov_reg   <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            leak_reg <= leak_next;
            cnt_reg  <= cnt_next;
            max_reg  <= max_next;
            ovf_reg  <= ovf_next;
            ov_reg   <= ov_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xneg_reg  <= xneg_next;
        last_reg  <= last_next;
        t_reg     <= t_next;
        n_reg     <= n_next;
        y_reg     <= y_next;
        term_reg  <= term_next;
        ssum_reg  <= ssum_next;
        k_reg     <= k_next;
        e_reg     <= e_next;
        e1_reg    <= e1_next;
        mah_reg   <= mah_next;
        mb_reg    <= mb_next;
        acc_reg   <= acc_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        idx_reg   <= idx_next;
        smsum_reg <= smsum_next;
        res_reg   <= res_next;
        eov_reg   <= eov_next;
        ovo_reg   <= ovo_next;
    end

    assign result          = res_reg;
    assign end_of_vector   = eov_reg;
    assign overflow        = ovo_reg;
    assign out_valid       = ov_reg;

    assign status.mode      = mode_reg;
    assign status.out_free  = !ov_reg || out_ready;
    assign status.div_busy  = dcnt_reg != '0;
    assign status.term_zero = term_reg == '0;
    assign status.k_end     = k_reg == K_W'(SER_TERMS);
    assign status.n_zero    = n_reg == '0;
    assign status.e_zero    = e_reg == '0;
    assign status.idx_last  = idx_last;

endmodule

// ----- hw/rtl/neural_activation_unit.sv -----
// identity, leaky relu, derivatives: one word per cycle unless output stalls, result next cycle
// sigmoid: exp series terms, then power steps, then the final quotient; one word at a time,
//   using the bit-serial divider shared by the exp series and the final quotient
// softmax: words buffered as they arrive; after last, one exp plus one divide per element
// reset: asynchronous active low, mode sigmoid, leak 41, empty buffer, no result pending
module neural_activation_unit import nau_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic signed [DATA_W-1:0] result,
    output logic                     end_of_vector,
    output logic                     overflow,
    output logic                     out_valid,
    input  logic                     out_ready
);

    nau_cmd_t    cmd;
    nau_status_t status;

    nau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    nau_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .last          (last),
        .result        (result),
        .end_of_vector (end_of_vector),
        .overflow      (overflow),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ----- hw/rtl/nau_checker.sv -----
module nau_assertions import nau_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [DATA_W-1:0] result,
    input logic                     end_of_vector,
    input logic                     overflow,
    input logic                     out_valid,
    input logic                     out_ready
);

    // pending word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped before accept");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result) && $stable(end_of_vector)
            && $stable(overflow))
        else $error("output word changed while stalled");

    // no new word taken while the output slot is blocked
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted with output slot full");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output word during reset");

endmodule

bind neural_activation_unit nau_assertions u_checker (.*);

// ----- tb/nau_checker.sv -----
module nau_checker import nau_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [DATA_W-1:0] result,
    input  logic                     end_of_vector,
    input  logic                     overflow,
    input  logic                     out_valid,
    input  logic                     out_ready,
    output int                       errors,
    output int                       pending
);

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     eov;
        logic                     ovf;
        int                       tol;
    } act_word_t;

    act_word_t expected_words[$];

    logic [MODE_W-1:0]        cur_mode;
    logic [LEAK_W-1:0]        cur_leak;
    logic signed [DATA_W-1:0] vec_buf [MAX_LEN];
    int                       vec_count;
    logic signed [DATA_W-1:0] vec_max;
    logic                     vec_ovf;

    initial errors = 0;
    initial pending = 0;

    function automatic logic signed [DATA_W-1:0] sat16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[DATA_W-1:0];
    endfunction

    // exp(-x), x and result in q32
    function automatic logic [63:0] exp_series(logic [63:0] x);
        longint     acc;
        logic [63:0] term;
        int         k;
        acc = 0;
        term = 64'h1_0000_0000;
        for (k = 0; k < 24 && term != 0; k++)
        begin
            if (k & 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
            term = ((term * (x >> 1)) >> 31) / 64'(k + 1);
        end
        if (acc < 0)
            acc = 0;
        if (acc > 64'sh1_0000_0000)
            acc = 64'sh1_0000_0000;
        return 64'(acc);
    endfunction

    function automatic logic [63:0] exp_neg(logic [31:0] t);
        logic [31:0] n;
        logic [63:0] e;
        logic [63:0] e1;
        n = t >> FRAC_BITS;
        e = exp_series(64'(t & (ONE_FX - 1)) << (32 - FRAC_BITS));
        if (n != 0)
        begin
            e1 = exp_series(64'h1_0000_0000);
            while (n != 0 && e != 0)
            begin
                e = (e * e1 + (64'd1 << 31)) >> 32;
                n--;
            end
        end
        return e;
    endfunction

    function automatic longint sigmoid_fx(logic signed [DATA_W-1:0] x);
        logic [31:0] mag;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        mag = (x < 0) ? 32'(-longint'(x)) : 32'(longint'(x));
        e = exp_neg(mag);
        den = 64'h1_0000_0000 + e;
        num = (x >= 0) ? (64'h1_0000_0000 << FRAC_BITS) : (e << FRAC_BITS);
        return longint'((num + den / 2) / den);
    endfunction

    task automatic expect_word(longint v, logic eov, logic ovf, int tol);
        act_word_t w;
        w.value = sat16(v);
        w.eov = eov;
        w.ovf = ovf;
        w.tol = tol;
        expected_words.push_back(w);
    endtask

    task automatic predict_activation(logic signed [DATA_W-1:0] x, logic lst);
        longint      r;
        longint      xl;
        logic [63:0] eq [MAX_LEN];
        logic [63:0] total;
        logic [31:0] t;
        int          i;
        xl = longint'(x);
        if (cur_mode == MODE_SOFTMAX)
        begin
            if (vec_count < MAX_LEN)
            begin
                vec_buf[vec_count] = x;
                vec_count++;
                if (x > vec_max)
                    vec_max = x;
            end
            else
                vec_ovf = 1'b1;
            if (lst)
            begin
                total = 0;
                for (i = 0; i < vec_count; i++)
                begin
                    t = 32'(longint'(vec_max) - longint'(vec_buf[i]));
                    eq[i] = (exp_neg(t) + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
                    total += eq[i];
                end
                if (total == 0)
                    total = 1;
                for (i = 0; i < vec_count; i++)
                begin
                    r = longint'((eq[i] * 64'(ONE_FX) + total / 2) / total);
                    expect_word(r, (i + 1 == vec_count), vec_ovf, 1);
                end
                vec_count = 0;
                vec_max = 16'sh8000;
                vec_ovf = 1'b0;
            end
        end
        else
        begin
            case (cur_mode)
                MODE_SIGMOID: r = sigmoid_fx(x);
                MODE_LEAKY:   r = (xl > 0) ? xl : ((xl * longint'(cur_leak) + 2048) >>> 12);
                MODE_SIG_D:   r = (xl * (ONE_FX - xl) + HALF_FX) >>> FRAC_BITS;
                MODE_ID_D:    r = ONE_FX;
                MODE_RELU_D:  r = (xl >= 0) ? ONE_FX : ((longint'(cur_leak) * ONE_FX + 2048) / 4096);
                default:      r = xl;
            endcase
            expect_word(r, lst, 1'b0, (cur_mode == MODE_SIGMOID) ? 1 : 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        act_word_t w;
        longint    diff;
        if (!rst_n)
        begin
            cur_mode = MODE_SIGMOID;
            cur_leak = LEAK_W'(LEAK_RESET);
            vec_count = 0;
            vec_max = 16'sh8000;
            vec_ovf = 1'b0;
            expected_words.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MODE)
                    cur_mode = cfg_data[MODE_W-1:0];
                else
                    cur_leak = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word result=%0d eov=%0b ovf=%0b",
                             $time, result, end_of_vector, overflow);
                end
                else
                begin
                    w = expected_words.pop_front();
                    diff = longint'(result) - longint'(w.value);
                    if (diff > w.tol || -diff > w.tol || end_of_vector !== w.eov
                        || overflow !== w.ovf)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %0d/%0b/%0b actual %0d/%0b/%0b",
                                 $time, w.value, w.eov, w.ovf,
                                 result, end_of_vector, overflow);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_activation(sample, last);
            pending = expected_words.size();
        end
    end

endmodule

// ----- tb/neural_activation_unit_tb.sv -----
module neural_activation_unit_tb;
    import nau_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic signed [DATA_W-1:0] sample = '0;
    logic                     last = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] result;
    logic                     end_of_vector;
    logic                     overflow;
    logic                     out_valid;
    logic                     out_ready = 1'b0;

    int errors;
    int pending;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int items = 0;

    always #10 clk = ~clk;

    neural_activation_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sample(sample), .last(last), .in_valid(in_valid),
        .in_ready(in_ready), .result(result), .end_of_vector(end_of_vector),
        .overflow(overflow), .out_valid(out_valid), .out_ready(out_ready)
    );

    nau_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sample(sample), .last(last), .in_valid(in_valid),
        .in_ready(in_ready), .result(result), .end_of_vector(end_of_vector),
        .overflow(overflow), .out_valid(out_valid), .out_ready(out_ready),
        .errors(errors), .pending(pending)
    );

    // receiver side, long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(99) >= recv_stall);
    end

    task automatic set_idling(int p);
        case (p % 5)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 66; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 66; end
            3: begin send_idle = 17; recv_stall = 17; end
            default: begin send_idle = 0; recv_stall = 0; end
        endcase
    endtask

    task automatic send_word(logic signed [DATA_W-1:0] s, logic l);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        sample = s;
        last = l;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items++;
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        drain();
        repeat (30) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(4))
            0: return DATA_W'($urandom);
            1: return DATA_W'($urandom_range(16383)) - 16'sd8192;
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return DATA_W'($urandom_range(32767)) - 16'sd16384;
        endcase
    endfunction

    task automatic send_vector(int len);
        int i;
        for (i = 0; i < len; i++)
            send_word(pick_sample(), i == len - 1);
    endtask

    initial
    begin
        int m;
        int n;
        int i;
        int p;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sigmoid from reset
        send_word(16'sh0000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh1000, 1'b1);
        send_word(-16'sh1000, 1'b0);
        for (m = MODE_IDENTITY; m <= 7; m++)
        begin
            write_reg(REG_MODE, m);
            if (m == MODE_LEAKY)
                write_reg(REG_LEAK, 4096);
            if (m == MODE_RELU_D)
                write_reg(REG_LEAK, 0);
            send_word(16'sh7fff, 1'b0);
            send_word(16'sh8000, 1'b1);
            send_word(-16'sh0001, 1'b0);
        end
        write_reg(REG_LEAK, 41);
        write_reg(REG_MODE, MODE_LEAKY);
        send_word(-16'sh0003, 1'b1);

        // receiver holds off while the sender keeps offering
        write_reg(REG_MODE, MODE_IDENTITY);
        hold_left = 300;
        for (i = 0; i < 12; i++)
            send_word(pick_sample(), i == 11);
        drain();

        // softmax: single element, equal extremes, partial vector across a mode change
        write_reg(REG_MODE, MODE_SOFTMAX);
        send_word(16'sh8000, 1'b1);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b1);
        send_word(16'sh0100, 1'b0);
        send_word(-16'sh0200, 1'b0);
        write_reg(REG_MODE, MODE_IDENTITY);
        send_word(16'sh0123, 1'b0);
        write_reg(REG_MODE, MODE_SOFTMAX);
        send_word(16'sh0400, 1'b1);
        // buffer overflow
        set_idling(3);
        send_vector(MAX_LEN + 4);
        drain();

        p = 0;
        while (items < 430)
        begin
            set_idling(p);
            p++;
            m = $urandom_range(7);
            if ($urandom_range(2) == 0)
            begin
                case ($urandom_range(3))
                    0: write_reg(REG_LEAK, 0);
                    1: write_reg(REG_LEAK, 4096);
                    default: write_reg(REG_LEAK, $urandom_range(4096));
                endcase
            end
            write_reg(REG_MODE, m);
            if (m == MODE_SOFTMAX)
            begin
                for (n = 0; n < 3; n++)
                    send_vector($urandom_range(8, 1));
            end
            else
            begin
                n = (m == MODE_SIGMOID) ? 4 : 20;
                for (i = 0; i < n; i++)
                    send_word(pick_sample(), $urandom_range(3) == 0);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/nau_pkg.sv
hw/rtl/nau_ram.sv
hw/rtl/nau_ctrl.sv
hw/rtl/nau_dp.sv
hw/rtl/neural_activation_unit.sv
hw/rtl/nau_checker.sv
tb/nau_checker.sv
tb/neural_activation_unit_tb.sv
